[sv/wfhus_pkg.sv]
// Package for the weighted flow-hash uplink selector.
// Holds sizes, operation codes and the hash mixer constants; no dependencies.
package wfhus_pkg;
    localparam int PROFILES          = 16;
    localparam int SLOTS_PER_PROFILE = 8;
    localparam int MAX_UPLINKS       = 16;
    localparam int PROF_W  = 4;
    localparam int SLOT_W  = 3;
    localparam int ADDR_W  = PROF_W + SLOT_W;
    localparam int DEPTH   = PROFILES * SLOTS_PER_PROFILE;
    localparam int ENTRY_W = 21;
    localparam int SUM_W   = 19;

    localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

    localparam logic [1:0] OP_WRITE_SLOT  = 2'd0;
    localparam logic [1:0] OP_WRITE_COUNT = 2'd1;
    localparam logic [1:0] OP_SELECT      = 2'd2;
    localparam logic [1:0] OP_NONE        = 2'd3;

    localparam logic [0:0] REG_TOTAL_UPLINKS = 1'd0;
    localparam logic [0:0] REG_PROFILES      = 1'd1;

    typedef struct packed {
        logic signed [15:0] weight;
        logic signed [4:0]  uplink;
    } t_entry;

    typedef struct packed {
        logic        we;
        logic [ADDR_W-1:0] waddr;
        t_entry      wdata;
        logic        re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;
endpackage

[sv/weighted_flow_hash_uplink_select.sv]
// Weighted flow-hash uplink selector: slot table in a registered-read RAM, counts in flops.
// A select runs the hash, a sum walk over the slot weights, the divide, a pick walk and a
// final read and check; a zero weight sum skips the pick walk, and a bad or empty profile
// returns after the hash. Writes never make the block busy. One item at a time.
// Synchronous active-low reset clears the config registers, counts and control; the slot RAM is
// not cleared. The receiver cannot stall: o_valid pulses for one cycle per select.
module weighted_flow_hash_uplink_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_profile,
    input  logic [2:0]  i_slot,
    input  logic signed [15:0] i_weight,
    input  logic signed [4:0]  i_uplink_index,
    input  logic [3:0]  i_slot_count,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_proto,
    output logic        o_valid,
    output logic        o_found,
    output logic [3:0]  o_chosen_uplink,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_SUM, S_DIV, S_WALK, S_PICK, S_CHECK
    } t_state;

    t_state r_state;
    logic [4:0] r_total_uplinks, r_profiles;
    logic [3:0] r_counts [wfhus_pkg::PROFILES];
    logic [3:0] r_prof;
    logic [3:0] r_cnt;
    logic [3:0] r_idx;      // slot address issued to the RAM
    logic [3:0] r_seen;     // slots whose data has come back
    logic [1:0] r_hstep;
    logic [wfhus_pkg::SUM_W-1:0] r_sum, r_acc;
    logic [31:0] r_seed;
    logic        r_div_go;
    logic        r_zero_sum;

    wfhus_pkg::t_mem_req req;
    wfhus_pkg::t_entry   rdata;
    logic [31:0] hash;
    logic        div_done;
    logic [wfhus_pkg::SUM_W-1:0] div_rem;
    logic        accept, cfg_wr;
    logic [4:0]  lim;
    logic [wfhus_pkg::SUM_W-1:0] pos_w, n_acc;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign lim    = (r_total_uplinks > 5'(wfhus_pkg::MAX_UPLINKS)) ?
                    5'(wfhus_pkg::MAX_UPLINKS) : r_total_uplinks;
    assign pos_w  = (rdata.weight > 16'sd0) ?
                    {{(wfhus_pkg::SUM_W-16){1'b0}}, rdata.weight} : '0;
    assign n_acc  = r_acc + pos_w;

    always_comb begin
        unique case (paddr[2])
            wfhus_pkg::REG_TOTAL_UPLINKS: prdata = {27'd0, r_total_uplinks};
            default:                      prdata = {27'd0, r_profiles};
        endcase
    end

    // RAM port: slot writes from the command, reads always enabled at the walk address
    always_comb begin
        req.we    = accept && (i_operation == wfhus_pkg::OP_WRITE_SLOT);
        req.waddr = {i_profile, i_slot};
        req.wdata = '{weight: i_weight, uplink: i_uplink_index};
        req.re    = 1'b1;
        req.raddr = {r_prof, r_idx[2:0]};
    end

    wfhus_slot_ram u_ram (.i_clk(i_clk), .i_req(req), .o_rdata(rdata));

    wfhus_hash u_hash (
        .i_clk(i_clk), .i_seed(r_seed), .i_step(r_hstep), .o_hash(hash)
    );

    wfhus_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_dividend(hash), .i_divisor(r_sum), .o_done(div_done), .o_rem(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_total_uplinks <= '0;
            r_profiles      <= '0;
            for (int p = 0; p < wfhus_pkg::PROFILES; p++) r_counts[p] <= '0;
            o_valid         <= 1'b0;
            o_found         <= 1'b0;
            o_chosen_uplink <= '0;
            r_div_go        <= 1'b0;
            r_hstep         <= 2'd3;
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            if (cfg_wr) begin
                unique case (paddr[2])
                    wfhus_pkg::REG_TOTAL_UPLINKS: r_total_uplinks <= pwdata[4:0];
                    default:                      r_profiles      <= pwdata[4:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prof <= i_profile;
                        r_seed <= i_src_ip ^ i_dst_ip ^ {i_src_port, 16'd0}
                                  ^ {16'd0, i_dst_port} ^ {24'd0, i_proto};
                        unique case (i_operation)
                            wfhus_pkg::OP_WRITE_COUNT:
                                r_counts[i_profile] <=
                                    (i_slot_count > 4'(wfhus_pkg::SLOTS_PER_PROFILE)) ?
                                    4'(wfhus_pkg::SLOTS_PER_PROFILE) : i_slot_count;
                            wfhus_pkg::OP_SELECT: begin
                                r_state <= S_HASH;
                                r_hstep <= 2'd0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_HASH: begin
                    r_hstep <= r_hstep + 2'd1;
                    if (r_hstep == 2'd2) begin
                        r_cnt <= r_counts[r_prof];
                        if ({1'b0, r_prof} >= r_profiles
                            || r_counts[r_prof] == 4'd0) begin
                            o_valid         <= 1'b1;
                            o_found         <= 1'b0;
                            o_chosen_uplink <= '0;
                            r_state         <= S_IDLE;
                        end else begin
                            r_idx   <= 4'd0;
                            r_seen  <= 4'd0;
                            r_acc   <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    // address runs one slot ahead; data comes back in the next cycle
                    r_idx <= r_idx + 4'd1;
                    if (r_idx != 4'd0) begin
                        r_acc  <= n_acc;
                        r_seen <= r_seen + 4'd1;
                        if (r_seen + 4'd1 == r_cnt) begin
                            // zero sum: slot = hash mod count, same divider
                            r_zero_sum <= (n_acc == '0);
                            r_sum      <= (n_acc == '0) ?
                                          {{(wfhus_pkg::SUM_W-4){1'b0}}, r_cnt} : n_acc;
                            r_div_go   <= 1'b1;
                            r_state    <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_zero_sum) begin
                            r_idx   <= {1'b0, div_rem[2:0]};
                            r_state <= S_PICK;
                        end else begin
                            r_idx   <= 4'd0;
                            r_seen  <= 4'd0;
                            r_acc   <= '0;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_idx <= r_idx + 4'd1;
                    if (r_idx != 4'd0) begin
                        r_acc  <= n_acc;
                        r_seen <= r_seen + 4'd1;
                        if (pos_w != '0 && div_rem < n_acc) begin
                            r_idx   <= r_seen;
                            r_state <= S_PICK;
                        end else if (r_seen + 4'd1 == r_cnt) begin
                            r_idx   <= r_cnt - 4'd1;
                            r_state <= S_PICK;
                        end
                    end
                end
                S_PICK: begin
                    // RAM read of the chosen slot in flight
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    o_valid <= 1'b1;
                    if (rdata.uplink >= 5'sd0 && {1'b0, 4'(rdata.uplink)} < lim) begin
                        o_found         <= 1'b1;
                        o_chosen_uplink <= 4'(rdata.uplink);
                    end else begin
                        o_found         <= 1'b0;
                        o_chosen_uplink <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/wfhus_slot_ram.sv]
// Slot table: single write, single registered read port.
// Depends on wfhus_pkg.
module wfhus_slot_ram (
    input  logic              i_clk,
    input  wfhus_pkg::t_mem_req i_req,
    output wfhus_pkg::t_entry o_rdata
);
    wfhus_pkg::t_entry mem [wfhus_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end
endmodule

[sv/wfhus_divider.sv]
// Restoring divider: 32-bit dividend by 19-bit divisor, one bit per cycle.
// Depends on wfhus_pkg.
module wfhus_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_dividend,
    input  logic [wfhus_pkg::SUM_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [wfhus_pkg::SUM_W-1:0] o_rem
);
    logic [31:0]                 r_quo;
    logic [wfhus_pkg::SUM_W:0]   r_rem;
    logic [wfhus_pkg::SUM_W-1:0] r_div;
    logic [5:0]                  r_cnt;
    logic                        r_busy;
    logic [wfhus_pkg::SUM_W:0]   n_shift;

    assign n_shift = {r_rem[wfhus_pkg::SUM_W-1:0], r_quo[31]};
    assign o_rem   = r_rem[wfhus_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // shift in next dividend bit, subtract when it fits
                r_quo <= {r_quo[30:0], 1'b0};
                if (n_shift >= {1'b0, r_div}) begin
                    r_rem <= n_shift - {1'b0, r_div};
                end else begin
                    r_rem <= n_shift;
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

[sv/wfhus_hash.sv]
// Flow hash mixer: xor-shift-multiply over three registered steps.
// Depends on wfhus_pkg.
module wfhus_hash (
    input  logic        i_clk,
    input  logic [31:0] i_seed,
    input  logic [1:0]  i_step,
    output logic [31:0] o_hash
);
    logic [31:0] n_val;

    always_comb begin
        unique case (i_step)
            2'd0:    n_val = (i_seed ^ (i_seed >> 16)) * wfhus_pkg::MIX_MUL_A;
            2'd1:    n_val = (o_hash ^ (o_hash >> 15)) * wfhus_pkg::MIX_MUL_B;
            2'd2:    n_val = o_hash ^ (o_hash >> 16);
            default: n_val = o_hash;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_hash <= n_val;
    end
endmodule

[sv/wfhus_checker.sv]
// Port-level checks for the uplink selector, bound to the top level.
// Depends on wfhus_pkg and the weighted_flow_hash_uplink_select ports only.
module wfhus_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_valid,
    input logic       o_found,
    input logic [3:0] o_chosen_uplink
);
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_chosen_uplink == 4'd0) else $error("nonzero uplink");
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result longer than one cycle");
    a_busy_after_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == wfhus_pkg::OP_SELECT |=> busy)
        else $error("select not taken");
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without select");
endmodule

bind weighted_flow_hash_uplink_select wfhus_checker u_chk (.*);
